// File: hw/rtl/aes192_pkg.sv
// ----------------------------------------------------------------------------
// AES-192 package
// Shared types, constants and byte-level functions for the AES-192 cipher.
// ----------------------------------------------------------------------------
package aes192_pkg;

  localparam int NumRoundsDef = 12;
  localparam int KeyIdxW      = 2;

  // configuration register indexes
  localparam logic [KeyIdxW-1:0] RegKey0 = 2'd0;
  localparam logic [KeyIdxW-1:0] RegKey1 = 2'd1;
  localparam logic [KeyIdxW-1:0] RegKey2 = 2'd2;

  // mode codes
  localparam logic ModeEnc = 1'b0;
  localparam logic ModeDec = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    logic [KeyIdxW-1:0] index;
    logic [63:0]        data;
  } cfg_item_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  // forward substitution table
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // inverse substitution table
  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage

// File: hw/rtl/aes192_keysched.sv
// ----------------------------------------------------------------------------
// AES-192 key schedule
// Produces the 52 schedule words one per cycle; each group of four is written
// to the round key memory as one 128-bit round key.
// ----------------------------------------------------------------------------
module aes192_keysched #(
  parameter int NUM_ROUNDS = aes192_pkg::NumRoundsDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [191:0] key,
  output logic         busy,
  output logic         wr_en,
  output logic [3:0]   wr_addr,
  output logic [127:0] wr_data
);
  import aes192_pkg::*;

  localparam int NumWords = 4 * (NUM_ROUNDS + 1);

  logic [5:0]   widx;      // index of the word being produced
  logic [191:0] win;       // last six words, newest in bits 31:0
  logic [95:0]  grp;       // three earlier words of current round key
  logic [7:0]   rc;
  logic [2:0]   phase;     // widx mod 6
  logic [31:0]  tw;
  logic [31:0]  nw;

  // next schedule word
  always_comb begin
    tw = win[31:0];
    if (phase == 3'd0) begin
      tw = {SBOX[win[23:16]] ^ rc, SBOX[win[15:8]], SBOX[win[7:0]], SBOX[win[31:24]]};
    end
    nw = win[191:160] ^ tw;
  end

  // sequencing; write data is registered so it lines up with wr_en
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      wr_en <= 1'b0;
      widx  <= '0;
    end else begin
      wr_en <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        widx  <= '0;
        phase <= '0;
        rc    <= 8'h01;
      end else if (busy) begin
        logic [31:0] w;
        w = (widx < 6'd6) ? key[191 - 32*widx[2:0] -: 32] : nw;
        win <= {win[159:0], w};
        grp <= {grp[63:0], w};
        if (widx >= 6'd6 && phase == 3'd0) rc <= xt(rc);
        phase <= (phase == 3'd5) ? 3'd0 : phase + 3'd1;
        if (widx[1:0] == 2'd3) begin
          wr_en   <= 1'b1;
          wr_addr <= widx[5:2];
          wr_data <= {grp, w};
        end
        if (widx == 6'(NumWords - 1)) busy <= 1'b0;
        widx <= widx + 6'd1;
      end
    end
  end
endmodule

// File: hw/rtl/aes192_round.sv
// ----------------------------------------------------------------------------
// AES-192 round unit
// One forward or inverse round on a 128-bit state; shared over all rounds.
// ----------------------------------------------------------------------------
module aes192_round (
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  logic         inverse,
  input  logic         last,
  output logic [127:0] state_out
);
  import aes192_pkg::*;

  logic [7:0] s [16];
  logic [7:0] o [16];
  logic [7:0] k [16];
  logic [7:0] m [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[127 - 8*i -: 8];
      k[i] = round_key[127 - 8*i -: 8];
    end
    // substitute and shift rows
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse) o[((c + r) % 4) * 4 + r] = ISBOX[s[c*4 + r]];
        else o[c*4 + r] = SBOX[s[((c + r) % 4) * 4 + r]];
      end
    end
    // forward: mix then key; inverse: key then mix
    if (inverse) begin
      for (int i = 0; i < 16; i++) o[i] = o[i] ^ k[i];
    end
    for (int c = 0; c < 4; c++) begin
      if (last) begin
        for (int r = 0; r < 4; r++) m[c*4 + r] = o[c*4 + r];
      end else if (inverse) begin
        m[c*4]   = gmul(o[c*4],4'd14) ^ gmul(o[c*4+1],4'd11) ^ gmul(o[c*4+2],4'd13) ^
                   gmul(o[c*4+3],4'd9);
        m[c*4+1] = gmul(o[c*4],4'd9) ^ gmul(o[c*4+1],4'd14) ^ gmul(o[c*4+2],4'd11) ^
                   gmul(o[c*4+3],4'd13);
        m[c*4+2] = gmul(o[c*4],4'd13) ^ gmul(o[c*4+1],4'd9) ^ gmul(o[c*4+2],4'd14) ^
                   gmul(o[c*4+3],4'd11);
        m[c*4+3] = gmul(o[c*4],4'd11) ^ gmul(o[c*4+1],4'd13) ^ gmul(o[c*4+2],4'd9) ^
                   gmul(o[c*4+3],4'd14);
      end else begin
        m[c*4]   = xt(o[c*4]) ^ gmul(o[c*4+1],4'd3) ^ o[c*4+2] ^ o[c*4+3];
        m[c*4+1] = o[c*4] ^ xt(o[c*4+1]) ^ gmul(o[c*4+2],4'd3) ^ o[c*4+3];
        m[c*4+2] = o[c*4] ^ o[c*4+1] ^ xt(o[c*4+2]) ^ gmul(o[c*4+3],4'd3);
        m[c*4+3] = gmul(o[c*4],4'd3) ^ o[c*4+1] ^ o[c*4+2] ^ xt(o[c*4+3]);
      end
    end
    if (!inverse) begin
      for (int i = 0; i < 16; i++) m[i] = m[i] ^ k[i];
    end
    for (int i = 0; i < 16; i++) state_out[127 - 8*i -: 8] = m[i];
  end
endmodule

// File: hw/rtl/aes192_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// AES-192 block cipher unit
// ECB encrypt/decrypt of 128-bit blocks with a 192-bit key.
//
// channel | direction | handshake           | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_item_t (index, data)
// in      | in        | in_valid/in_ready   | in_item_t
// out     | out       | out_valid/out_ready | out_item_t
//
// A block passes through the accept state, a fetch of the first round key,
// 13 round-key steps (the initial key addition in the sequencer, then 12 rounds
// through the shared round unit, each step one read of the round key memory)
// and the output register, where it waits until taken.
// After reset or a key write, the next block first runs the key expansion:
// start, 52 schedule words at one per cycle, last write, handoff.
// rst is synchronous; in_ready is low while a block is in flight (cfg_ready stays high).
// ----------------------------------------------------------------------------
module aes192_block_cipher_unit #(
  parameter int NUM_ROUNDS = aes192_pkg::NumRoundsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  aes192_pkg::cfg_item_t cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aes192_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aes192_pkg::out_item_t out_item
);
  import aes192_pkg::*;

  localparam int NumKeys = NUM_ROUNDS + 1;

  typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_FETCH, S_ROUND, S_DONE} state_t;

  state_t       state;
  logic [63:0]  key0, key1, key2;
  logic         sched_ok;
  logic         mode_r, last_r;
  logic [127:0] work;
  logic [3:0]   rnd;
  logic [127:0] rk_mem [NumKeys];
  logic [127:0] rk;
  logic [3:0]   rd_addr;
  logic         ks_start, ks_busy, ks_we;
  logic [3:0]   ks_addr;
  logic [127:0] ks_data;
  logic [127:0] rnd_out;
  logic         first;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign out_item  = '{result_hi: work[127:64], result_lo: work[63:0], last_out: last_r};
  // one start pulse per expansion
  assign ks_start  = (state == S_EXPAND) && !first;

  aes192_keysched #(.NUM_ROUNDS(NUM_ROUNDS)) u_ks (
    .clk(clk), .rst(rst), .start(ks_start), .key({key0, key1, key2}),
    .busy(ks_busy), .wr_en(ks_we), .wr_addr(ks_addr), .wr_data(ks_data)
  );

  aes192_round u_round (
    .state_in(work), .round_key(rk), .inverse(mode_r),
    .last(rnd == 4'(NUM_ROUNDS)), .state_out(rnd_out)
  );

  // round key memory, registered read
  always_ff @(posedge clk) begin
    if (ks_we) rk_mem[ks_addr] <= ks_data;
    rk <= rk_mem[rd_addr];
  end

  // key index for the next step
  always_comb begin
    logic [3:0] step;
    step = (state == S_ROUND) ? rnd + 4'd1 : 4'd0;
    rd_addr = (mode_r == ModeDec) ? 4'(NUM_ROUNDS) - step : step;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= '0;
      key1 <= '0;
      key2 <= '0;
    end else if (cfg_valid) begin
      unique case (cfg.index)
        RegKey0: key0 <= cfg.data;
        RegKey1: key1 <= cfg.data;
        RegKey2: key2 <= cfg.data;
        default: ;
      endcase
    end
  end

  // block sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sched_ok <= 1'b0;
      rnd      <= '0;
      work     <= '0;
      first    <= 1'b0;
    end else begin
      if (cfg_valid && (cfg.index == RegKey0 || cfg.index == RegKey1 ||
                        cfg.index == RegKey2)) sched_ok <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= in_item.mode;
            last_r <= in_item.last_block;
            work   <= {in_item.block_hi, in_item.block_lo};
            state  <= sched_ok ? S_FETCH : S_EXPAND;
            first  <= 1'b0;
          end
        end
        S_EXPAND: begin
          if (ks_start) first <= 1'b1;
          else if (first && !ks_busy && !ks_we) begin
            sched_ok <= 1'b1;
            state    <= S_FETCH;
          end
        end
        S_FETCH: begin
          // read of the first step's round key is in flight
          state <= S_ROUND;
          rnd   <= '0;
        end
        S_ROUND: begin
          if (rnd == 4'd0) work <= work ^ rk;
          else work <= rnd_out;
          if (rnd == 4'(NUM_ROUNDS)) state <= S_DONE;
          rnd <= rnd + 4'd1;
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
            rnd   <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: dv/aes192_block_cipher_unit_tb.sv
// ----------------------------------------------------------------------------
// AES-192 block cipher unit testbench
// Drives keys and blocks through the valid/ready channels, predicts every
// result with a behavioral AES-192 (key schedule, cipher, inverse cipher)
// and compares each result transaction field by field, in order.
// ----------------------------------------------------------------------------
module aes192_block_cipher_unit_tb;
  import aes192_pkg::*;

  typedef logic [7:0] byte_arr_t [16];

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_item_t cfg = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // predictor state
  logic [63:0]  key_w [3];
  logic [127:0] sched [13];
  logic [7:0]   fbox [256];
  logic [7:0]   ibox [256];
  out_item_t    cipher_q [$];

  int  fail_cnt = 0;
  int  idle_cycles = 0;
  int  stall_mode = 0;
  int  burst_left = 0;
  bit  drain_done = 1'b0;

  aes192_block_cipher_unit dut (.*);

  always #5 clk = ~clk;

  // ---------------- GF(2^8) arithmetic and boxes ----------------
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // boxes built from field inverse plus affine map
  task automatic build_boxes();
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
      if (x == 0) inv = 8'h00;
      b = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
      fbox[x] = b;
      ibox[b] = x[7:0];
    end
  endtask

  // ---------------- key schedule ----------------
  task automatic expand_schedule();
    logic [31:0] w [52];
    logic [191:0] k;
    logic [31:0] t;
    logic [7:0] rc;
    k = {key_w[0], key_w[1], key_w[2]};
    rc = 8'h01;
    for (int i = 0; i < 6; i++) w[i] = k[191 - 32*i -: 32];
    for (int i = 6; i < 52; i++) begin
      t = w[i-1];
      if (i % 6 == 0) begin
        t = {fbox[t[23:16]] ^ rc, fbox[t[15:8]], fbox[t[7:0]], fbox[t[31:24]]};
        rc = gf_dbl(rc);
      end
      w[i] = w[i-6] ^ t;
    end
    for (int r = 0; r < 13; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  // ---------------- cipher rounds ----------------
  function automatic byte_arr_t add_rk(input byte_arr_t s, input int r);
    for (int i = 0; i < 16; i++) s[i] ^= sched[r][127 - 8*i -: 8];
    return s;
  endfunction

  function automatic byte_arr_t sub_shift(input byte_arr_t s, input bit inv);
    byte_arr_t o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inv) o[((c + r) % 4) * 4 + r] = ibox[s[c*4 + r]];
        else     o[c*4 + r] = fbox[s[((c + r) % 4) * 4 + r]];
    return o;
  endfunction

  function automatic byte_arr_t mix_cols(input byte_arr_t s, input bit inv);
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] m0, m1, m2, m3;
    {m0, m1, m2, m3} = inv ? {8'd14, 8'd11, 8'd13, 8'd9} : {8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      {a0, a1, a2, a3} = {s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]};
      s[4*c]   = gf_mul(a0, m0) ^ gf_mul(a1, m1) ^ gf_mul(a2, m2) ^ gf_mul(a3, m3);
      s[4*c+1] = gf_mul(a0, m3) ^ gf_mul(a1, m0) ^ gf_mul(a2, m1) ^ gf_mul(a3, m2);
      s[4*c+2] = gf_mul(a0, m2) ^ gf_mul(a1, m3) ^ gf_mul(a2, m0) ^ gf_mul(a3, m1);
      s[4*c+3] = gf_mul(a0, m1) ^ gf_mul(a1, m2) ^ gf_mul(a2, m3) ^ gf_mul(a3, m0);
    end
    return s;
  endfunction

  function automatic out_item_t aes_transform(input in_item_t it);
    byte_arr_t s;
    logic [127:0] blk;
    out_item_t res;
    blk = {it.block_hi, it.block_lo};
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8];
    if (it.mode == ModeEnc) begin
      s = add_rk(s, 0);
      for (int r = 1; r < 12; r++) s = add_rk(mix_cols(sub_shift(s, 0), 0), r);
      s = add_rk(sub_shift(s, 0), 12);
    end else begin
      s = add_rk(s, 12);
      for (int r = 11; r >= 1; r--) s = mix_cols(add_rk(sub_shift(s, 1), r), 1);
      s = add_rk(sub_shift(s, 1), 0);
    end
    for (int i = 0; i < 16; i++) blk[127 - 8*i -: 8] = s[i];
    res.result_hi = blk[127:64];
    res.result_lo = blk[63:0];
    res.last_out  = it.last_block;
    return res;
  endfunction

  // ---------------- drivers ----------------
  task automatic write_key(input logic [KeyIdxW-1:0] idx, input logic [63:0] val);
    // let a valid dropped in this time step settle first
    if (cfg_valid) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    key_w[idx] = val;
    expand_schedule();
  endtask

  // sends one block; burst/gap shaping happens before raising valid
  task automatic send_block(input in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    burst_left--;
    // let a valid dropped in this time step settle first
    if (in_valid) @(posedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cipher_q.push_back(aes_transform(it));
    in_valid <= 1'b0;
  endtask

  function automatic in_item_t rand_block();
    in_item_t it;
    it.mode       = 1'($urandom_range(0, 1));
    it.block_hi   = {$urandom, $urandom};
    it.block_lo   = {$urandom, $urandom};
    it.last_block = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // idle boundary: every result back, then pad for the block latency
  task automatic wait_drained();
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_key(input logic [191:0] k);
    wait_drained();
    write_key(RegKey0, k[191:128]);
    write_key(RegKey1, k[127:64]);
    write_key(RegKey2, k[63:0]);
  endtask

  // ---------------- tests ----------------
  task automatic test_reset_key();
    // all-zero key straight out of reset, extreme data
    send_block('{ModeEnc, 64'h0, 64'h0, 1'b0});
    send_block('{ModeDec, 64'h0, 64'h0, 1'b1});
    send_block('{ModeEnc, '1, '1, 1'b1});
    send_block('{ModeDec, '1, '1, 1'b0});
  endtask

  task automatic test_fips_vector();
    // FIPS-197 appendix C.2 key and plaintext, both directions
    load_key(192'h000102030405060708090a0b0c0d0e0f1011121314151617);
    send_block('{ModeEnc, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0});
    send_block('{ModeDec, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1'b1});
    send_block('{ModeEnc, 64'h8000000000000000, 64'h1, 1'b0});
    send_block('{ModeDec, 64'h1, 64'h8000000000000000, 1'b1});
  endtask

  task automatic test_key_extremes();
    load_key('1);
    send_block('{ModeEnc, 64'h0, '1, 1'b0});
    send_block('{ModeDec, '1, 64'h0, 1'b1});
    // single-word rewrite must trigger a fresh expansion
    wait_drained();
    write_key(RegKey1, 64'h5555555555555555);
    send_block('{ModeEnc, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b1});
    send_block('{ModeDec, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0});
    // unknown index is ignored by the block
    wait_drained();
    cfg_valid <= 1'b1;
    cfg <= '{index: 2'd3, data: '1};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    send_block('{ModeEnc, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0});
    load_key('0);
    send_block('{ModeEnc, '1, 64'h0, 1'b1});
  endtask

  task automatic test_random_blocks();
    for (int ph = 0; ph < 6; ph++) begin
      load_key({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      stall_mode = ph % 3;
      repeat (125) send_block(rand_block());
    end
  endtask

  // ---------------- receiver stall pattern ----------------
  always @(posedge clk) begin
    case (stall_mode)
      0: out_ready <= ($urandom_range(0, 3) != 0);
      1: out_ready <= 1'b1;
      default: out_ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected result transaction %h", out_item);
        fail_cnt++;
      end else begin
        exp_res = cipher_q.pop_front();
        if (out_item.result_hi !== exp_res.result_hi) begin
          $error("result_hi: expected %h, got %h", exp_res.result_hi, out_item.result_hi);
          fail_cnt++;
        end
        if (out_item.result_lo !== exp_res.result_lo) begin
          $error("result_lo: expected %h, got %h", exp_res.result_lo, out_item.result_lo);
          fail_cnt++;
        end
        if (out_item.last_out !== exp_res.last_out) begin
          $error("last_out: expected %b, got %b", exp_res.last_out, out_item.last_out);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || drain_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("aes192_block_cipher_unit_tb: FAIL");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    key_w = '{default: '0};
    build_boxes();
    expand_schedule();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_fips_vector();
    test_key_extremes();
    test_random_blocks();
    while (cipher_q.size() != 0) @(posedge clk);
    drain_done = 1'b1;
    repeat (100) @(posedge clk);
    if (fail_cnt == 0 && cipher_q.size() == 0)
      $display("aes192_block_cipher_unit_tb: PASS");
    else
      $display("aes192_block_cipher_unit_tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/aes192_pkg.sv
hw/rtl/aes192_keysched.sv
hw/rtl/aes192_round.sv
hw/rtl/aes192_block_cipher_unit.sv
dv/aes192_block_cipher_unit_tb.sv
